@@ rtl/cascaded_biquad_filter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded biquad filter unit
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_FILTER_UNIT_ASSERT_SVH
`define CASCADED_BIQUAD_FILTER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CBQF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CBQF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cbqf_pkg.sv @@
// ----------------------------------------------------------------------------
// cbqf_pkg
// Shared types and constants of the cascaded biquad filter unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cbqf_pkg;

    localparam int SECTIONS_DEF       = 5;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 28;

    localparam int COEF_BITS = 32;
    localparam int DATA_BITS = 32;
    localparam int ACC_BITS  = 68;
    localparam int CNT_BITS  = 5;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] REG_B0    = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_B1    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_B2    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_D1    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_D2    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_COUNT = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_ORDER = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_GAIN  = 3'd7;

    localparam logic [1:0] ORDER_FIRST  = 2'd1;
    localparam logic [1:0] ORDER_SECOND = 2'd2;

    typedef struct packed {
        logic start;
        logic clear;
    } cbqf_mac_ctrl_t;

    typedef struct packed {
        logic busy;
    } cbqf_mac_stat_t;

endpackage

`default_nettype wire

@@ rtl/cbqf_in_if.sv @@
// ----------------------------------------------------------------------------
// cbqf_in_if
// Input sample channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbqf_in_if #(parameter int SAMPLE_BITS = 24);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

@@ rtl/cbqf_out_if.sv @@
// ----------------------------------------------------------------------------
// cbqf_out_if
// Output sample channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbqf_out_if #(parameter int SAMPLE_BITS = 24);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ rtl/cbqf_cfg_if.sv @@
// ----------------------------------------------------------------------------
// cbqf_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbqf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/cbqf_mac.sv @@
// ----------------------------------------------------------------------------
// cbqf_mac
// Bit-serial multiply-accumulate: one coefficient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cbqf_mac
    import cbqf_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cbqf_mac_ctrl_t              ctrl,
    input  wire logic [COEF_BITS-1:0]        coef,
    input  wire logic signed [DATA_BITS-1:0] val,
    output cbqf_mac_stat_t                   stat,
    output logic signed [ACC_BITS-1:0]       acc
);

    logic                       busy_reg;
    logic [CNT_BITS-1:0]        cnt_reg;
    logic [COEF_BITS-1:0]       coef_sh_reg;
    logic signed [ACC_BITS-1:0] mult_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] addend;
    logic                       last_bit;

    assign last_bit = (cnt_reg == CNT_BITS'(COEF_BITS - 1));

    always_comb
    begin
        addend = '0;
        if (coef_sh_reg[0])
        begin
            addend = last_bit ? -mult_reg : mult_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last_bit)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            coef_sh_reg <= coef;
            mult_reg    <= ACC_BITS'(val);
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            coef_sh_reg <= coef_sh_reg >> 1;
            mult_reg    <= mult_reg <<< 1;
            acc_reg     <= acc_reg + addend;
        end
    end

    assign stat.busy = busy_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

@@ rtl/cascaded_biquad_filter_unit.sv @@
// ----------------------------------------------------------------------------
// cascaded_biquad_filter_unit
// Chain of direct-form-1 IIR sections sharing one coefficient set, followed
// by an output gain; one bit-serial multiply-accumulate unit does all taps.
//
// Channel   Role    Handshake     Payload
// in_ch     sink    valid/ready   sample_in  [SAMPLE_BITS]
// out_ch    source  valid/ready   sample_out [SAMPLE_BITS]
// cfg       sink    valid/ready   index [3], data [32]
//
// Each tap is issued to the serial multiplier, which steps through all 32
// coefficient bits while the unit waits; taps are 3 or 5 per section, and
// an order that is neither first nor second sends samples through the gain
// alone. Reset clears all delays and loads default registers. A finished
// sample waits in the output register; the next sample is taken meanwhile
// and stalls only at its own output write.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_biquad_filter_unit
    import cbqf_pkg::*;
#(
    parameter int SECTIONS       = SECTIONS_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    cbqf_in_if.sink   in_ch,
    cbqf_out_if.source out_ch,
    cbqf_cfg_if.sink  cfg
);

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic signed [ACC_BITS-1:0] RND =
        ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] D_MAX = ACC_BITS'(32'sh7fffffff);
    localparam logic signed [ACC_BITS-1:0] D_MIN = -D_MAX - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] S_MAX =
        (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] S_MIN = -S_MAX - ACC_BITS'(1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TAP   = 7'b0000010,
        ST_WAIT  = 7'b0000100,
        ST_SECT  = 7'b0001000,
        ST_GAIN  = 7'b0010000,
        ST_GWAIT = 7'b0100000,
        ST_PUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [COEF_BITS-1:0] b0_reg, b1_reg, b2_reg, d1_reg, d2_reg, gain_reg;
    logic [2:0]           count_reg;
    logic [1:0]           order_reg;

    logic signed [DATA_BITS-1:0] x1_reg [SECTIONS];
    logic signed [DATA_BITS-1:0] x2_reg [SECTIONS];
    logic signed [DATA_BITS-1:0] y1_reg [SECTIONS];
    logic signed [DATA_BITS-1:0] y2_reg [SECTIONS];

    logic signed [DATA_BITS-1:0] cur_reg;
    logic [SEC_W-1:0]            sec_reg, last_sec_reg, last_sec;
    logic [2:0]                  tap_reg, last_tap;
    logic                        out_valid_reg;
    logic [SAMPLE_BITS-1:0]      out_data_reg;

    cbqf_mac_ctrl_t              mac_ctrl;
    cbqf_mac_stat_t              mac_stat;
    logic [COEF_BITS-1:0]        mac_coef;
    logic signed [DATA_BITS-1:0] mac_val;
    logic signed [ACC_BITS-1:0]  mac_acc;
    logic signed [ACC_BITS-1:0]  rounded;
    logic signed [DATA_BITS-1:0] y_sat;
    logic signed [ACC_BITS-1:0]  s_sat;
    logic [4:0]                  n_sel;
    logic                        order_ok;
    logic                        in_acc, out_free;
    logic                        put_now;
    logic                        in_sect;

    cbqf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .coef  (mac_coef),
        .val   (mac_val),
        .stat  (mac_stat),
        .acc   (mac_acc)
    );

    assign cfg.ready    = 1'b1;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign put_now      = (state_reg == ST_PUT) && out_free;
    assign in_sect      = (state_reg == ST_TAP) || (state_reg == ST_WAIT) ||
                          (state_reg == ST_SECT);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.sample_out = out_data_reg;

    assign order_ok = (order_reg == ORDER_FIRST) || (order_reg == ORDER_SECOND);
    assign last_tap = (order_reg == ORDER_FIRST) ? 3'd2 : 3'd4;

    always_comb
    begin
        n_sel = {2'b00, count_reg};
        if (n_sel == 5'd0)
        begin
            n_sel = 5'd1;
        end
        if (n_sel > 5'(SECTIONS))
        begin
            n_sel = 5'(SECTIONS);
        end
        last_sec = SEC_W'(n_sel - 5'd1);
    end

    always_comb
    begin
        case (tap_reg)
            3'd0:    begin mac_coef = b0_reg; mac_val = cur_reg;          end
            3'd1:    begin mac_coef = b1_reg; mac_val = x1_reg[sec_reg];  end
            3'd2:    begin mac_coef = d1_reg; mac_val = y1_reg[sec_reg];  end
            3'd3:    begin mac_coef = b2_reg; mac_val = x2_reg[sec_reg];  end
            3'd4:    begin mac_coef = d2_reg; mac_val = y2_reg[sec_reg];  end
            default: begin mac_coef = b0_reg; mac_val = cur_reg;          end
        endcase
        if (state_reg == ST_GAIN)
        begin
            mac_coef = gain_reg;
            mac_val  = cur_reg;
        end
    end

    always_comb
    begin
        mac_ctrl.start = (state_reg == ST_TAP) || (state_reg == ST_GAIN);
        mac_ctrl.clear = (state_reg == ST_GAIN) || (tap_reg == 3'd0);
    end

    always_comb
    begin
        rounded = (mac_acc + RND) >>> COEF_FRAC_BITS;
        if (rounded > D_MAX)
        begin
            y_sat = DATA_BITS'(D_MAX);
        end
        else if (rounded < D_MIN)
        begin
            y_sat = DATA_BITS'(D_MIN);
        end
        else
        begin
            y_sat = DATA_BITS'(rounded);
        end
        if (rounded > S_MAX)
        begin
            s_sat = S_MAX;
        end
        else if (rounded < S_MIN)
        begin
            s_sat = S_MIN;
        end
        else
        begin
            s_sat = rounded;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = order_ok ? ST_TAP : ST_GAIN;
                end
            end
            ST_TAP:   state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (!mac_stat.busy)
                begin
                    state_next = (tap_reg == last_tap) ? ST_SECT : ST_TAP;
                end
            end
            ST_SECT:  state_next = (sec_reg == last_sec_reg) ? ST_GAIN : ST_TAP;
            ST_GAIN:  state_next = ST_GWAIT;
            ST_GWAIT:
            begin
                if (!mac_stat.busy)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            b0_reg        <= COEF_BITS'(1) << COEF_FRAC_BITS;
            b1_reg        <= '0;
            b2_reg        <= '0;
            d1_reg        <= '0;
            d2_reg        <= '0;
            gain_reg      <= COEF_BITS'(1) << COEF_FRAC_BITS;
            count_reg     <= 3'd1;
            order_reg     <= ORDER_SECOND;
            sec_reg       <= '0;
            last_sec_reg  <= '0;
            tap_reg       <= '0;
            for (int i = 0; i < SECTIONS; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_B0:    b0_reg    <= cfg.data;
                    REG_B1:    b1_reg    <= cfg.data;
                    REG_B2:    b2_reg    <= cfg.data;
                    REG_D1:    d1_reg    <= cfg.data;
                    REG_D2:    d2_reg    <= cfg.data;
                    REG_COUNT: count_reg <= cfg.data[2:0];
                    REG_ORDER: order_reg <= cfg.data[1:0];
                    REG_GAIN:  gain_reg  <= cfg.data;
                    default:   ;
                endcase
            end

            if (put_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    sec_reg      <= '0;
                    tap_reg      <= '0;
                    last_sec_reg <= last_sec;
                end
                ST_WAIT:
                begin
                    if (!mac_stat.busy && (tap_reg != last_tap))
                    begin
                        tap_reg <= tap_reg + 3'd1;
                    end
                end
                ST_SECT:
                begin
                    if (order_reg == ORDER_SECOND)
                    begin
                        x2_reg[sec_reg] <= x1_reg[sec_reg];
                        y2_reg[sec_reg] <= y1_reg[sec_reg];
                    end
                    x1_reg[sec_reg] <= cur_reg;
                    y1_reg[sec_reg] <= y_sat;
                    tap_reg         <= '0;
                    sec_reg         <= sec_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_reg <= DATA_BITS'(signed'(in_ch.sample_in));
        end
        else if (state_reg == ST_SECT)
        begin
            cur_reg <= y_sat;
        end
        if (put_now)
        begin
            out_data_reg <= s_sat[SAMPLE_BITS-1:0];
        end
    end

`include "cascaded_biquad_filter_unit_assert.svh"

    `CBQF_ASSERT_IMPL(a_idle_mac, clk, rst_n, state_reg == ST_IDLE, !mac_stat.busy, "mac busy in idle")
    `CBQF_ASSERT_IMPL(a_sec_range, clk, rst_n, in_sect, sec_reg <= last_sec_reg, "section index past last")
    `CBQF_ASSERT_NEXT(a_put_out, clk, rst_n, put_now, out_valid_reg, "result not presented")

endmodule

`default_nettype wire
